FILE: hw/rtl/lsf_pkg.sv
// Types, register indexes and helpers of the line substring filter.
// Used by lsf_cell, lsf_result_queue, the top level and the testbench; depends on nothing.
package lsf_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CountW   = 32;
  localparam int unsigned QueueDepth = 4;

  localparam logic [CfgIdxW-1:0] RegPatternLow    = 4'd0;
  localparam logic [CfgIdxW-1:0] RegPatternHigh   = 4'd1;
  localparam logic [CfgIdxW-1:0] RegPatternLength = 4'd2;
  localparam logic [CfgIdxW-1:0] RegIgnoreCase    = 4'd3;
  localparam logic [CfgIdxW-1:0] RegInvertMatch   = 4'd4;
  localparam logic [CfgIdxW-1:0] RegCountMode     = 4'd5;
  localparam logic [CfgIdxW-1:0] RegNumberLines   = 4'd6;
  localparam logic [CfgIdxW-1:0] RegQuietMode     = 4'd7;

  localparam logic KindLine    = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef struct packed {
    logic advance;
    logic clear;
  } lsf_cell_ctrl_t;

  typedef struct packed {
    logic              item_kind;
    logic [CountW-1:0] line_number;
    logic              line_matched;
    logic              print_line;
    logic              print_number;
    logic [CountW-1:0] total_count;
    logic              any_match;
    logic              last_result;
  } lsf_result_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic fold_en);
    logic [7:0] r;
    r = c;
    if (fold_en && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

FILE: hw/rtl/lsf_if.sv
// Valid/ready channels of the line substring filter: text words in, result words out.
// Depends on nothing.
interface lsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       line_last;
  logic       file_last;

  modport source (output valid, text_byte, line_last, file_last, input ready);
  modport sink   (input valid, text_byte, line_last, file_last, output ready);
endinterface

interface lsf_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [31:0] line_number;
  logic        line_matched;
  logic        print_line;
  logic        print_number;
  logic [31:0] total_count;
  logic        any_match;
  logic        last_result;

  modport source (output valid, item_kind, line_number, line_matched, print_line,
                  print_number, total_count, any_match, last_result, input ready);
  modport sink   (input valid, item_kind, line_number, line_matched, print_line,
                  print_number, total_count, any_match, last_result, output ready);
endinterface

FILE: hw/rtl/lsf_cell.sv
// One match cell: holds the flag "pattern bytes up to this one matched so far".
// Depends on lsf_pkg.
module lsf_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lsf_pkg::lsf_cell_ctrl_t ctrl_i,
  input  logic [7:0]             text_i,
  input  logic [7:0]             pat_i,
  input  logic                   prev_i,
  input  logic                   last_i,
  output logic                   flag_o,
  output logic                   hit_o
);
  import lsf_pkg::*;

  logic flag_q, flag_d, match;

  assign match = prev_i && (text_i == pat_i);

  always_comb begin
    flag_d = flag_q;
    if (ctrl_i.advance) begin
      flag_d = match;
    end
    if (ctrl_i.clear) begin
      flag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_d;
    end
  end

  assign flag_o = flag_q;
  assign hit_o  = ctrl_i.advance && match && last_i;

endmodule

FILE: hw/rtl/lsf_result_queue.sv
// Shift queue of result words: up to two words in, one word out per cycle.
// Depends on lsf_pkg.
module lsf_result_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           push_n_i,
  input  lsf_pkg::lsf_result_t push_data_i [2],
  input  logic                 pop_i,
  output logic                 space_o,
  output logic                 valid_o,
  output lsf_pkg::lsf_result_t head_o
);
  import lsf_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  lsf_result_t slot_q [DEPTH];
  lsf_result_t slot_d [DEPTH];
  logic [CW-1:0] count_q, count_d, base;

  always_comb begin
    base    = count_q - CW'(pop_i);
    count_d = base + CW'(push_n_i);
    for (int j = 0; j < DEPTH; j++) begin
      slot_d[j] = slot_q[j];
      if (pop_i && j < DEPTH - 1) begin
        slot_d[j] = slot_q[j + 1];
      end
      if (push_n_i != 2'd0 && CW'(j) == base) begin
        slot_d[j] = push_data_i[0];
      end
      if (push_n_i == 2'd2 && CW'(j) == base + 1'b1) begin
        slot_d[j] = push_data_i[1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DEPTH; j++) begin
      slot_q[j] <= slot_d[j];
    end
  end

  assign space_o = (count_q <= CW'(DEPTH - 2));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[0];

endmodule

FILE: hw/rtl/line_substring_filter_unit.sv
// Line substring filter: top level with registers, line control and the cell row.
// Depends on lsf_pkg, lsf_if, lsf_cell and lsf_result_queue.
//
// Takes one text word per cycle. A row of PATTERN_MAX cells tracks partial
// matches of the pattern, each cell comparing the incoming byte with one
// pattern byte and passing its flag to the next cell, so a match on the final
// byte of a line is decided in the cycle that byte is accepted. Results go
// through a four-entry queue: a line end gives one result word, a file end two,
// a quiet-mode hit one summary word and a halted file none; the input is ready
// while the queue has two free entries, so a steady stream runs at one word per
// cycle as long as the sink takes result words as fast as they are made. The user
// must write configuration only while the block is idle; no logic enforces it.
module line_substring_filter_unit #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lsf_pkg::CfgDataW-1:0]   cfg_data_i,
  lsf_in_if.sink                         text_i,
  lsf_out_if.source                      result_o
);
  import lsf_pkg::*;

  logic [63:0] pat_lo_q, pat_hi_q;
  logic [4:0]  plen_q;
  logic        icase_q, invert_q, cmode_q, number_q, quiet_q;

  logic              line_hit_q, line_hit_d;
  logic              stopped_q, stopped_d;
  logic [CountW-1:0] line_cnt_q, line_cnt_d;
  logic [CountW-1:0] hit_cnt_q, hit_cnt_d;
  logic [CountW-1:0] miss_cnt_q, miss_cnt_d;
  logic              seen_q, seen_d;
  logic              halted_q, halted_d;

  logic              in_acc, line_end, matched, pl, len_zero, hit_now, space;
  logic [7:0]        text_fold;
  lsf_cell_ctrl_t    cell_ctrl;
  lsf_result_t       push_data [2];
  logic [1:0]        push_n;
  lsf_result_t       head;
  logic              q_valid;

  logic [PATTERN_MAX-1:0] nz, in_use, is_last, flag, hit;
  logic [7:0]             pat_fold [PATTERN_MAX];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      plen_q   <= '0;
      icase_q  <= 1'b0;
      invert_q <= 1'b0;
      cmode_q  <= 1'b0;
      number_q <= 1'b0;
      quiet_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegPatternLow:    pat_lo_q <= cfg_data_i;
        RegPatternHigh:   pat_hi_q <= cfg_data_i;
        RegPatternLength: plen_q   <= cfg_data_i[4:0];
        RegIgnoreCase:    icase_q  <= cfg_data_i[0];
        RegInvertMatch:   invert_q <= cfg_data_i[0];
        RegCountMode:     cmode_q  <= cfg_data_i[0];
        RegNumberLines:   number_q <= cfg_data_i[0];
        RegQuietMode:     quiet_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_acc    = text_i.valid && text_i.ready;
  assign line_end  = text_i.line_last || text_i.file_last;
  assign text_fold = fold(text_i.text_byte, icase_q);

  assign cell_ctrl.advance = in_acc && !halted_q && !stopped_q && (text_i.text_byte != 8'd0);
  assign cell_ctrl.clear   = in_acc && line_end;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [7:0] pat_raw;
    if (k < 8) begin : g_lo
      assign pat_raw = pat_lo_q[8*k +: 8];
    end else begin : g_hi
      assign pat_raw = pat_hi_q[8*(k-8) +: 8];
    end
    assign pat_fold[k] = fold(pat_raw, icase_q);
    assign nz[k]       = (pat_raw != 8'd0);
    assign in_use[k]   = (5'(k) < plen_q) && (&nz[k:0]);
    if (k == PATTERN_MAX - 1) begin : g_end
      assign is_last[k] = in_use[k];
    end else begin : g_mid
      assign is_last[k] = in_use[k] && !in_use[k+1];
    end

    lsf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .text_i (text_fold),
      .pat_i  (pat_fold[k]),
      .prev_i ((k == 0) ? 1'b1 : flag[(k == 0) ? 0 : k-1]),
      .last_i (is_last[k]),
      .flag_o (flag[k]),
      .hit_o  (hit[k])
    );
  end

  assign len_zero = !in_use[0];
  assign hit_now  = |hit;
  assign matched  = line_hit_q || hit_now || len_zero;
  assign pl       = !cmode_q && (matched != invert_q);

  always_comb begin
    line_hit_d = line_hit_q;
    stopped_d  = stopped_q;
    line_cnt_d = line_cnt_q;
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    seen_d     = seen_q;
    halted_d   = halted_q;
    push_n     = 2'd0;
    push_data[0] = '0;
    push_data[1] = '0;

    if (in_acc && halted_q) begin
      if (text_i.file_last) begin
        halted_d   = 1'b0;
        line_cnt_d = '0;
        hit_cnt_d  = '0;
        miss_cnt_d = '0;
        seen_d     = 1'b0;
        line_hit_d = 1'b0;
        stopped_d  = 1'b0;
      end
    end else if (in_acc) begin
      if (!stopped_q && text_i.text_byte == 8'd0) begin
        stopped_d = 1'b1;
      end
      if (hit_now) begin
        line_hit_d = 1'b1;
      end
      if (line_end) begin
        line_cnt_d = sat_inc(line_cnt_q);
        if (matched) begin
          hit_cnt_d = sat_inc(hit_cnt_q);
          seen_d    = 1'b1;
        end else begin
          miss_cnt_d = sat_inc(miss_cnt_q);
        end
        line_hit_d = 1'b0;
        stopped_d  = 1'b0;

        push_data[0].line_number = line_cnt_d;
        push_data[0].total_count = invert_q ? miss_cnt_d : hit_cnt_d;
        push_data[0].any_match   = seen_d;
        push_data[1] = push_data[0];

        if (matched && quiet_q) begin
          push_n = 2'd1;
          push_data[0].item_kind    = KindSummary;
          push_data[0].line_matched = 1'b1;
          push_data[0].last_result  = 1'b1;
          halted_d = !text_i.file_last;
        end else begin
          push_n = text_i.file_last ? 2'd2 : 2'd1;
          push_data[0].item_kind    = KindLine;
          push_data[0].line_matched = matched;
          push_data[0].print_line   = pl;
          push_data[0].print_number = pl && matched && number_q;
          push_data[0].last_result  = !text_i.file_last;
          push_data[1].item_kind    = KindSummary;
          push_data[1].last_result  = 1'b1;
        end

        if (text_i.file_last) begin
          line_cnt_d = '0;
          hit_cnt_d  = '0;
          miss_cnt_d = '0;
          seen_d     = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_hit_q <= 1'b0;
      stopped_q  <= 1'b0;
      line_cnt_q <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      seen_q     <= 1'b0;
      halted_q   <= 1'b0;
    end else begin
      line_hit_q <= line_hit_d;
      stopped_q  <= stopped_d;
      line_cnt_q <= line_cnt_d;
      hit_cnt_q  <= hit_cnt_d;
      miss_cnt_q <= miss_cnt_d;
      seen_q     <= seen_d;
      halted_q   <= halted_d;
    end
  end

  lsf_result_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_data_i (push_data),
    .pop_i       (result_o.valid && result_o.ready),
    .space_o     (space),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  assign text_i.ready          = space;
  assign result_o.valid        = q_valid;
  assign result_o.item_kind    = head.item_kind;
  assign result_o.line_number  = head.line_number;
  assign result_o.line_matched = head.line_matched;
  assign result_o.print_line   = head.print_line;
  assign result_o.print_number = head.print_number;
  assign result_o.total_count  = head.total_count;
  assign result_o.any_match    = head.any_match;
  assign result_o.last_result  = head.last_result;

  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> push_n == 2'd0)
    else $error("result pushed while halted");

  a_line_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !halted_q && line_end) |-> push_n != 2'd0)
    else $error("line end without a result word");

  a_quiet_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !halted_q && line_end && matched && quiet_q && !text_i.file_last)
      |=> halted_q)
    else $error("quiet hit did not halt");

  a_cells_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && line_end) |=> (flag == '0 && !line_hit_q && !stopped_q))
    else $error("line state not cleared at line end");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Testbench of line_substring_filter_unit: random idling on both channels and in-order
// checking of line decisions and file summaries against a predictor kept in this module.
// Depends on lsf_pkg, the lsf_in_if / lsf_out_if interfaces and line_substring_filter_unit.
module tb;
  import lsf_pkg::*;

  localparam int unsigned PatternMax   = 16;
  localparam int unsigned RegCount     = 8;
  localparam int unsigned LongHold     = 80;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned WordTarget   = 1050;
  localparam int unsigned CycleLimit   = 200000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  lsf_in_if  text_if ();
  lsf_out_if result_if ();

  line_substring_filter_unit #(.PATTERN_MAX(PatternMax)) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .text_i     (text_if),
    .result_o   (result_if)
  );

  // register mirror
  logic [63:0] pat_lo;
  logic [63:0] pat_hi;
  logic [4:0]  pat_len;
  logic        fold_on;
  logic        invert_on;
  logic        count_on;
  logic        numbers_on;
  logic        quiet_on;

  // per-file filter state
  logic [7:0]  window [PatternMax];
  logic        line_hit;
  logic        search_stopped;
  logic        seen_hit;
  logic        halted;
  logic [31:0] line_count;
  logic [31:0] hit_count;
  logic [31:0] miss_count;

  lsf_result_t pending_results[$];
  lsf_result_t oldest;
  int unsigned mismatches = 0;
  int unsigned searched_words = 0;
  bit          idle_on = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  logic        ready_next;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_file_state();
    int i;
    for (i = 0; i < PatternMax; i++) window[i] = 8'h00;
    line_hit = 1'b0;
    search_stopped = 1'b0;
    seen_hit = 1'b0;
    halted = 1'b0;
    line_count = '0;
    hit_count = '0;
    miss_count = '0;
  endfunction

  function automatic logic [7:0] pattern_byte(int unsigned i);
    if (i < 8) return pat_lo[8*i +: 8];
    return pat_hi[8*(i-8) +: 8];
  endfunction

  function automatic logic [7:0] folded(logic [7:0] c);
    if (fold_on && c >= 8'h41 && c <= 8'h5A) return c + 8'd32;
    return c;
  endfunction

  function automatic int unsigned active_len();
    int unsigned n, i;
    n = (pat_len > PatternMax) ? PatternMax : pat_len;
    for (i = 0; i < n; i++) begin
      if (pattern_byte(i) == 8'h00) return i;
    end
    return n;
  endfunction

  function automatic lsf_result_t make_result(logic kind, logic [31:0] num, logic matched,
                                              logic pl, logic pn, logic last);
    lsf_result_t r;
    r.item_kind    = kind;
    r.line_number  = num;
    r.line_matched = matched;
    r.print_line   = pl;
    r.print_number = pn;
    r.total_count  = invert_on ? miss_count : hit_count;
    r.any_match    = seen_hit;
    r.last_result  = last;
    return r;
  endfunction

  function automatic void filter_word(logic [7:0] b, logic ll, logic fl);
    int unsigned n, i;
    logic eq, matched, pl;
    n = active_len();
    if (halted) begin
      if (fl) clear_file_state();
      return;
    end
    searched_words++;
    if (!search_stopped) begin
      if (b == 8'h00) begin
        search_stopped = 1'b1;
      end else begin
        for (i = PatternMax - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = folded(b);
        eq = (n > 0);
        for (i = 0; i < n; i++) begin
          if (window[n-1-i] != folded(pattern_byte(i))) eq = 1'b0;
        end
        if (eq) line_hit = 1'b1;
      end
    end
    if (!ll && !fl) return;

    matched = line_hit || (n == 0);
    if (line_count != '1) line_count++;
    if (matched) begin
      if (hit_count != '1) hit_count++;
      seen_hit = 1'b1;
    end else begin
      if (miss_count != '1) miss_count++;
    end
    for (i = 0; i < PatternMax; i++) window[i] = 8'h00;
    line_hit = 1'b0;
    search_stopped = 1'b0;

    if (matched && quiet_on) begin
      pending_results.push_back(make_result(KindSummary, line_count, 1'b1, 1'b0, 1'b0, 1'b1));
      if (fl) clear_file_state();
      else halted = 1'b1;
      return;
    end
    pl = !count_on && (matched != invert_on);
    pending_results.push_back(make_result(KindLine, line_count, matched, pl,
                                          pl && matched && numbers_on, !fl));
    if (fl) begin
      pending_results.push_back(make_result(KindSummary, line_count, 1'b0, 1'b0, 1'b0, 1'b1));
      clear_file_state();
    end
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (result_if.valid && result_if.ready) stall_left = idle_on ? $urandom_range(3, 0) : 0;
    if (hold_req) begin
      hold_left = LongHold;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
    end
    result_if.ready <= ready_next;
  end

  always @(posedge clk) begin
    if (rst_n && result_if.valid && result_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word mismatch, expected none, actual kind %0h line %0h",
                 $time, result_if.item_kind, result_if.line_number);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("item_kind", 32'(oldest.item_kind), 32'(result_if.item_kind));
        check_field("line_number", oldest.line_number, result_if.line_number);
        check_field("line_matched", 32'(oldest.line_matched), 32'(result_if.line_matched));
        check_field("print_line", 32'(oldest.print_line), 32'(result_if.print_line));
        check_field("print_number", 32'(oldest.print_number), 32'(result_if.print_number));
        check_field("total_count", oldest.total_count, result_if.total_count);
        check_field("any_match", 32'(oldest.any_match), 32'(result_if.any_match));
        check_field("last_result", 32'(oldest.last_result), 32'(result_if.last_result));
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      RegPatternLow:    pat_lo = data;
      RegPatternHigh:   pat_hi = data;
      RegPatternLength: pat_len = data[4:0];
      RegIgnoreCase:    fold_on = data[0];
      RegInvertMatch:   invert_on = data[0];
      RegCountMode:     count_on = data[0];
      RegNumberLines:   numbers_on = data[0];
      RegQuietMode:     quiet_on = data[0];
      default: ;
    endcase
  endtask

  task automatic program_filter(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [4:0] len, input logic ic, input logic inv,
                                input logic cm, input logic nl, input logic qm);
    logic [CfgDataW-1:0] junk;
    logic [CfgIdxW-1:0]  spare_idx;
    junk = {$urandom, $urandom};
    spare_idx = CfgIdxW'($urandom_range(2**CfgIdxW - 1, RegCount));
    write_reg(RegPatternLow, lo);
    write_reg(RegPatternHigh, hi);
    write_reg(RegPatternLength, {junk[63:5], len});
    write_reg(spare_idx, junk);
    write_reg(RegIgnoreCase, {junk[63:1], ic});
    write_reg(RegInvertMatch, {junk[63:1], inv});
    write_reg(RegCountMode, {junk[63:1], cm});
    write_reg(RegNumberLines, {junk[63:1], nl});
    write_reg(RegQuietMode, {junk[63:1], qm});
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(input logic [7:0] b, input logic ll, input logic fl);
    int unsigned gap;
    gap = idle_on ? $urandom_range(3, 0) : 0;
    if (gap != 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_if.valid <= 1'b1;
    text_if.text_byte <= b;
    text_if.line_last <= ll;
    text_if.file_last <= fl;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    filter_word(b, ll, fl);
  endtask

  // drop valid, wait for every expected word, then let the pipeline settle
  task automatic end_phase();
    text_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [7:0] random_letter();
    if ($urandom_range(1, 0) == 1) return 8'(8'h61 + $urandom_range(2, 0));
    return 8'(8'h41 + $urandom_range(2, 0));
  endfunction

  function automatic logic [7:0] random_text(int unsigned plen);
    int unsigned r;
    r = $urandom_range(39, 0);
    if (r == 0) return 8'h00;
    if (r < 12 && plen != 0) return pattern_byte($urandom_range(plen - 1, 0));
    if (r < 22) return random_letter();
    return 8'($urandom_range(255, 1));
  endfunction

  task automatic random_filter_setup();
    logic [63:0] lo, hi;
    logic [4:0]  len;
    logic [7:0]  b;
    int unsigned i, r;
    lo = '0;
    hi = '0;
    for (i = 0; i < PatternMax; i++) begin
      r = $urandom_range(39, 0);
      if (r == 0) b = 8'h00;
      else if (r == 1) b = 8'hFF;
      else if (r < 28) b = random_letter();
      else b = 8'($urandom_range(255, 1));
      if (i < 8) lo[8*i +: 8] = b;
      else hi[8*(i-8) +: 8] = b;
    end
    case ($urandom_range(7, 0))
      0: len = 5'd0;
      1: len = 5'd16;
      2: len = 5'($urandom_range(31, 17));
      default: len = 5'($urandom_range(6, 1));
    endcase
    program_filter(lo, hi, len, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                   $urandom_range(3, 0) == 0, 1'($urandom_range(1, 0)),
                   $urandom_range(5, 0) == 0);
  endtask

  task automatic random_file();
    logic [7:0]  line_buf[$];
    logic [7:0]  c;
    logic        noisy, embed, ll, fl;
    int unsigned n_lines, line_idx, len, plen, pos, j, k;
    n_lines = $urandom_range(8, 1);
    noisy = ($urandom_range(9, 0) == 0);
    plen = active_len();
    for (line_idx = 0; line_idx < n_lines; line_idx++) begin
      len = ($urandom_range(3, 0) == 0) ? $urandom_range(24, 1) : $urandom_range(8, 1);
      embed = (plen != 0) && ($urandom_range(1, 0) == 1);
      if (embed && len < plen) len = plen;
      line_buf.delete();
      for (k = 0; k < len; k++) line_buf.push_back(random_text(plen));
      if (embed) begin
        pos = $urandom_range(len - plen, 0);
        for (j = 0; j < plen; j++) begin
          c = pattern_byte(j);
          if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
              $urandom_range(fold_on ? 1 : 7, 0) == 0) c ^= 8'h20;
          line_buf[pos + j] = c;
        end
      end
      for (k = 0; k < len; k++) begin
        ll = (k == len - 1);
        fl = ll && (line_idx == n_lines - 1);
        if (noisy) ll = ll || ($urandom_range(3, 0) == 0);
        if (fl && $urandom_range(3, 0) == 0) ll = 1'b0;
        send_word(line_buf[k], ll, fl);
      end
    end
  endtask

  task automatic test_case_fold_and_stop();
    idle_on = 1'b1;
    program_filter(64'h6241, '1, 5'd2, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    send_word(8'h61, 1'b0, 1'b0);
    send_word(8'h42, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h61, 1'b0, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b1);
    end_phase();
  endtask

  task automatic test_empty_pattern_invert();
    program_filter('1, '0, 5'd0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h7A, 1'b0, 1'b1);
    end_phase();
  endtask

  task automatic test_length_cutoff_count();
    program_filter(64'h7777_7777_007A_7978, {$urandom, $urandom}, 5'd31,
                   1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
    send_word(8'h78, 1'b0, 1'b0);
    send_word(8'h79, 1'b0, 1'b0);
    send_word(8'h7A, 1'b1, 1'b1);
    end_phase();
  endtask

  task automatic test_quiet_halt();
    program_filter(64'h71, '0, 5'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_word(8'h71, 1'b1, 1'b0);
    send_word(8'h78, 1'b1, 1'b0);
    send_word(8'h79, 1'b0, 1'b1);
    send_word(8'h71, 1'b1, 1'b1);
    end_phase();
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    program_filter(64'h61, '0, 5'd1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    hold_req = 1'b1;
    repeat (23) send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h61, 1'b1, 1'b1);
    end_phase();
  endtask

  task automatic test_random_files();
    while (searched_words < WordTarget) begin
      idle_on = ($urandom_range(3, 0) != 0);
      random_filter_setup();
      random_file();
      end_phase();
    end
  endtask

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("tb failed");
    $finish;
  end

  initial begin
    text_if.valid = 1'b0;
    text_if.text_byte = 8'h00;
    text_if.line_last = 1'b0;
    text_if.file_last = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pat_lo = '0;
    pat_hi = '0;
    pat_len = '0;
    fold_on = 1'b0;
    invert_on = 1'b0;
    count_on = 1'b0;
    numbers_on = 1'b0;
    quiet_on = 1'b0;
    clear_file_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_case_fold_and_stop();
    test_empty_pattern_invert();
    test_length_cutoff_count();
    test_quiet_halt();
    test_backpressure();
    test_random_files();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

FILE: line_substring_filter_unit.f
hw/rtl/lsf_pkg.sv
hw/rtl/lsf_if.sv
hw/rtl/lsf_cell.sv
hw/rtl/lsf_result_queue.sv
hw/rtl/line_substring_filter_unit.sv
dv/tb.sv
